// ===== rtl/ffwrl_pkg.sv =====
// ---------------------------------------------------------------------------
// ffwrl_pkg
// Shared widths, register indexes and reset values of the per-flow policer.
// ---------------------------------------------------------------------------
`default_nettype none

package ffwrl_pkg;

  // Item field widths
  localparam int KEY_W   = 64;
  localparam int LEN_W   = 16;
  localparam int TIME_W  = 64;
  localparam int PKT_W   = 32;
  localparam int BYTE_W  = 48;

  // Register widths
  localparam int MAXP_W  = 32;
  localparam int MAXB_W  = 40;
  localparam int WLEN_W  = 32;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 40;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_PACKETS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_BYTES     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 2'd2;

  localparam logic [WLEN_W-1:0] WINDOW_RESET = 32'd1000000000;

endpackage : ffwrl_pkg

`default_nettype wire

// ===== rtl/ffwrl_if.sv =====
// ---------------------------------------------------------------------------
// ffwrl_if
// Valid/ready channels of the policer: packet items, verdict items and
// configuration writes.
// ---------------------------------------------------------------------------
`default_nettype none

interface ffwrl_in_if;
  logic                        valid;
  logic                        ready;
  logic [ffwrl_pkg::KEY_W-1:0]  flow_key;
  logic [ffwrl_pkg::LEN_W-1:0]  packet_length;
  logic [ffwrl_pkg::TIME_W-1:0] now_time;

  modport source (output valid, output flow_key, output packet_length,
                  output now_time, input ready);
  modport sink   (input valid, input flow_key, input packet_length,
                  input now_time, output ready);
endinterface : ffwrl_in_if

interface ffwrl_out_if;
  logic                       valid;
  logic                       ready;
  logic                       drop;
  logic [ffwrl_pkg::PKT_W-1:0] packet_count;
  logic                       new_entry;

  modport source (output valid, output drop, output packet_count,
                  output new_entry, input ready);
  modport sink   (input valid, input drop, input packet_count,
                  input new_entry, output ready);
endinterface : ffwrl_out_if

interface ffwrl_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [ffwrl_pkg::CFG_IDX_W-1:0]  index;
  logic [ffwrl_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface : ffwrl_cfg_if

`default_nettype wire

// ===== rtl/flow_fixed_window_rate_limiter.sv =====
// ---------------------------------------------------------------------------
// flow_fixed_window_rate_limiter
// Per-flow fixed-window policer with a fully associative, LRU-replaced
// flow table. One verdict item per packet item.
// ---------------------------------------------------------------------------
// Path: input register, then lookup/update and result register; an item waits
//   beyond that path only while the sink stalls.
// Throughput: 1 item per cycle unless the sink stalls; table lookup, counter and LRU
//   age update for one item all settle in the single stage after the input reg.
// Reset: clears all entry valid bits, sets LRU ages to entry index order and
//   loads register reset values; config writes are taken every cycle.
`default_nettype none

module flow_fixed_window_rate_limiter #(
  parameter int ENTRIES = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  ffwrl_cfg_if.sink          cfg_i,
  ffwrl_in_if.sink           in_i,
  ffwrl_out_if.source        out_o
);

  localparam int IdxW = $clog2(ENTRIES);
  localparam logic [IdxW-1:0] OldestAge = IdxW'(ENTRIES - 1);

  // Configuration registers
  logic [ffwrl_pkg::MAXP_W-1:0] max_pkts_q;
  logic [ffwrl_pkg::MAXB_W-1:0] max_bytes_q;
  logic [ffwrl_pkg::WLEN_W-1:0] win_len_q;

  // Flow table
  logic [ENTRIES-1:0]            valid_q;
  logic [ffwrl_pkg::KEY_W-1:0]   key_q   [ENTRIES];
  logic [ffwrl_pkg::PKT_W-1:0]   pkts_q  [ENTRIES];
  logic [ffwrl_pkg::BYTE_W-1:0]  bytes_q [ENTRIES];
  logic [ffwrl_pkg::TIME_W-1:0]  start_q [ENTRIES];
  logic [IdxW-1:0]               age_q   [ENTRIES];
  logic [IdxW-1:0]               age_d   [ENTRIES];

  // Input register
  logic                          s1_valid_q;
  logic [ffwrl_pkg::KEY_W-1:0]   s1_key_q;
  logic [ffwrl_pkg::LEN_W-1:0]   s1_len_q;
  logic [ffwrl_pkg::TIME_W-1:0]  s1_now_q;

  // Result register
  logic                          out_valid_q;
  logic                          out_drop_q;
  logic [ffwrl_pkg::PKT_W-1:0]   out_count_q;
  logic                          out_new_q;

  logic s1_adv;
  logic in_take;

  // Lookup and update
  logic                          hit_found;
  logic [IdxW-1:0]               hit_idx;
  logic                          free_found;
  logic [IdxW-1:0]               free_idx;
  logic [IdxW-1:0]               lru_idx;
  logic [IdxW-1:0]               use_idx;
  logic [IdxW-1:0]               use_age;
  logic [ffwrl_pkg::PKT_W-1:0]   cur_pkts;
  logic [ffwrl_pkg::BYTE_W-1:0]  cur_bytes;
  logic [ffwrl_pkg::TIME_W-1:0]  cur_start;
  logic [ffwrl_pkg::TIME_W-1:0]  elapsed_time;
  logic                          elapsed;
  logic                          restart;
  logic [ffwrl_pkg::PKT_W-1:0]   pkts_inc;
  logic [ffwrl_pkg::BYTE_W:0]    byte_sum;
  logic [ffwrl_pkg::BYTE_W-1:0]  bytes_inc;
  logic [ffwrl_pkg::PKT_W-1:0]   new_pkts;
  logic [ffwrl_pkg::BYTE_W-1:0]  new_bytes;
  logic                          drop_d;

  assign s1_adv  = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign in_take = in_i.valid && in_i.ready;

  assign cfg_i.ready = 1'b1;

  assign out_o.valid        = out_valid_q;
  assign out_o.drop         = out_drop_q;
  assign out_o.packet_count = out_count_q;
  assign out_o.new_entry    = out_new_q;

  // ---------------------------------------------------------------------
  // Configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_pkts_q  <= '0;
      max_bytes_q <= '0;
      win_len_q   <= ffwrl_pkg::WINDOW_RESET;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        ffwrl_pkg::REG_MAX_PACKETS:   max_pkts_q  <= cfg_i.data[ffwrl_pkg::MAXP_W-1:0];
        ffwrl_pkg::REG_MAX_BYTES:     max_bytes_q <= cfg_i.data[ffwrl_pkg::MAXB_W-1:0];
        ffwrl_pkg::REG_WINDOW_LENGTH: win_len_q   <= cfg_i.data[ffwrl_pkg::WLEN_W-1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Associative search: first matching key, first free slot, oldest entry
  always_comb begin
    hit_found  = 1'b0;
    hit_idx    = '0;
    free_found = 1'b0;
    free_idx   = '0;
    lru_idx    = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (valid_q[i] && (key_q[i] == s1_key_q) && !hit_found) begin
        hit_found = 1'b1;
        hit_idx   = IdxW'(i);
      end
      if (!valid_q[i] && !free_found) begin
        free_found = 1'b1;
        free_idx   = IdxW'(i);
      end
      // ages are a permutation, so the oldest holds the top age
      if (age_q[i] == OldestAge) begin
        lru_idx = IdxW'(i);
      end
    end
  end

  assign use_idx = hit_found ? hit_idx : (free_found ? free_idx : lru_idx);
  assign use_age = age_q[use_idx];

  assign cur_pkts  = pkts_q[hit_idx];
  assign cur_bytes = bytes_q[hit_idx];
  assign cur_start = start_q[hit_idx];

  assign elapsed_time = s1_now_q - cur_start;
  assign elapsed = elapsed_time >= {{(ffwrl_pkg::TIME_W - ffwrl_pkg::WLEN_W){1'b0}}, win_len_q};
  assign restart = !hit_found || elapsed;

  // Saturating counters
  assign pkts_inc  = (cur_pkts == '1) ? cur_pkts : cur_pkts + ffwrl_pkg::PKT_W'(1);
  assign byte_sum  = {1'b0, cur_bytes} + (ffwrl_pkg::BYTE_W + 1)'(s1_len_q);
  assign bytes_inc = byte_sum[ffwrl_pkg::BYTE_W] ? '1 : byte_sum[ffwrl_pkg::BYTE_W-1:0];

  assign new_pkts  = restart ? ffwrl_pkg::PKT_W'(1) : pkts_inc;
  assign new_bytes = restart ? ffwrl_pkg::BYTE_W'(s1_len_q) : bytes_inc;

  assign drop_d = !restart &&
                  (((max_pkts_q != '0) && (pkts_inc > max_pkts_q)) ||
                   ((max_bytes_q != '0) &&
                    (bytes_inc > {{(ffwrl_pkg::BYTE_W - ffwrl_pkg::MAXB_W){1'b0}},
                                  max_bytes_q})));

  // Move the used entry to the front, age the ones younger than it
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (IdxW'(i) == use_idx) begin
        age_d[i] = '0;
      end else if (age_q[i] < use_age) begin
        age_d[i] = age_q[i] + IdxW'(1);
      end else begin
        age_d[i] = age_q[i];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Table state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        age_q[i] <= IdxW'(i);
      end
    end else if (s1_adv) begin
      valid_q[use_idx] <= 1'b1;
      for (int i = 0; i < ENTRIES; i++) begin
        age_q[i] <= age_d[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      key_q[use_idx]   <= s1_key_q;
      pkts_q[use_idx]  <= new_pkts;
      bytes_q[use_idx] <= new_bytes;
      if (restart) begin
        start_q[use_idx] <= s1_now_q;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_key_q <= in_i.flow_key;
      s1_len_q <= in_i.packet_length;
      s1_now_q <= in_i.now_time;
    end
  end

  // ---------------------------------------------------------------------
  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_drop_q  <= drop_d;
      out_count_q <= new_pkts;
      out_new_q   <= !hit_found;
    end
  end

endmodule : flow_fixed_window_rate_limiter

`default_nettype wire

// ===== rtl/ffwrl_checker.sv =====
// ---------------------------------------------------------------------------
// ffwrl_checker
// Port-level checks on the policer's verdict items, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module ffwrl_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        out_valid_i,
  input wire logic                        out_ready_i,
  input wire logic                        out_drop_i,
  input wire logic [ffwrl_pkg::PKT_W-1:0] out_count_i,
  input wire logic                        out_new_i
);

  // A freshly created entry always passes with a count of one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_new_i |-> !out_drop_i && (out_count_i == ffwrl_pkg::PKT_W'(1)))
    else $error("new entry item must pass with count one");

  // A drop only comes from an ongoing window, which has counted at least two
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_drop_i |->
      !out_new_i && (out_count_i != '0) && (out_count_i != ffwrl_pkg::PKT_W'(1)))
    else $error("drop outside an ongoing window");

  // Hold a stalled verdict item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(out_drop_i) && $stable(out_count_i) && $stable(out_new_i))
    else $error("stalled result item changed");

endmodule : ffwrl_checker

bind flow_fixed_window_rate_limiter ffwrl_checker u_ffwrl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_drop_i  (out_o.drop),
  .out_count_i (out_o.packet_count),
  .out_new_i   (out_o.new_entry)
);

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the per-flow fixed-window policer. A short table
// of directed packets runs on the reset register values, then random phases
// run under several limit and window settings. Each verdict is checked against
// its row's given values or a local model of the flow table with its LRU ages.
// ---------------------------------------------------------------------------

module testbench;

  localparam int ENTRIES     = 16;
  localparam int POOL_SIZE   = 20;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 290;
  localparam int LONG_HOLD   = 300;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_WAIT  = 10;

  // Index past the register list; the block must ignore it
  localparam logic [ffwrl_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  localparam logic [ffwrl_pkg::PKT_W-1:0]  PKT_SAT  = '1;
  localparam logic [ffwrl_pkg::BYTE_W-1:0] BYTE_SAT = '1;

  typedef struct packed {
    logic                        drop;
    logic [ffwrl_pkg::PKT_W-1:0] count;
    logic                        new_entry;
  } verdict_t;

  typedef struct {
    logic [ffwrl_pkg::KEY_W-1:0]  key;
    logic [ffwrl_pkg::LEN_W-1:0]  len;
    logic [ffwrl_pkg::TIME_W-1:0] stamp;
    bit                           typed;
    verdict_t                     want;
  } packet_row_t;

  logic clk;
  logic rst_n;

  ffwrl_cfg_if cfg_ch ();
  ffwrl_in_if  in_ch ();
  ffwrl_out_if out_ch ();

  flow_fixed_window_rate_limiter #(
    .ENTRIES (ENTRIES)
  ) u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_ch),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // Local copy of the registers and of the flow table
  logic [ffwrl_pkg::MAXP_W-1:0] lim_packets;
  logic [ffwrl_pkg::MAXB_W-1:0] lim_bytes;
  logic [ffwrl_pkg::WLEN_W-1:0] win_len;

  logic                         flow_valid [ENTRIES];
  logic [ffwrl_pkg::KEY_W-1:0]  flow_key   [ENTRIES];
  logic [ffwrl_pkg::PKT_W-1:0]  flow_pkts  [ENTRIES];
  logic [ffwrl_pkg::BYTE_W-1:0] flow_bytes [ENTRIES];
  logic [ffwrl_pkg::TIME_W-1:0] flow_start [ENTRIES];
  int unsigned                  flow_age   [ENTRIES];

  verdict_t                     pending_verdicts [$];
  packet_row_t                  directed_rows [$];
  logic [ffwrl_pkg::KEY_W-1:0]  key_pool [POOL_SIZE];
  logic [ffwrl_pkg::TIME_W-1:0] now_base;

  int error_count;
  int packet_total, new_total, evict_total, restart_total, drop_total;
  bit send_idle_en, recv_idle_en, long_hold_req;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Move the used entry to the front and age every younger one
  function automatic void touch_flow(int e);
    int unsigned a;
    a = flow_age[e];
    for (int i = 0; i < ENTRIES; i++) begin
      if (flow_age[i] < a) flow_age[i]++;
    end
    flow_age[e] = 0;
  endfunction

  function automatic verdict_t police_packet(logic [ffwrl_pkg::KEY_W-1:0] key,
                                             logic [ffwrl_pkg::LEN_W-1:0] len,
                                             logic [ffwrl_pkg::TIME_W-1:0] stamp);
    verdict_t v;
    int       hit;
    int       victim;
    bit       found;
    bit       free_found;
    v.drop      = 1'b0;
    v.count     = 1;
    v.new_entry = 1'b0;
    hit         = 0;
    victim      = 0;
    found       = 1'b0;
    free_found  = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (flow_valid[i] && flow_key[i] == key && !found) begin
        found = 1'b1;
        hit   = i;
      end
    end
    if (found) begin
      if (stamp - flow_start[hit] >= 64'(win_len)) begin
        flow_pkts[hit]  = 1;
        flow_bytes[hit] = ffwrl_pkg::BYTE_W'(len);
        flow_start[hit] = stamp;
        restart_total++;
      end else begin
        if (flow_pkts[hit] != PKT_SAT) flow_pkts[hit]++;
        if (flow_bytes[hit] > BYTE_SAT - ffwrl_pkg::BYTE_W'(len)) flow_bytes[hit] = BYTE_SAT;
        else flow_bytes[hit] = flow_bytes[hit] + ffwrl_pkg::BYTE_W'(len);
        if (lim_packets != 0 && flow_pkts[hit] > lim_packets) v.drop = 1'b1;
        if (lim_bytes != 0 && flow_bytes[hit] > ffwrl_pkg::BYTE_W'(lim_bytes)) v.drop = 1'b1;
        v.count = flow_pkts[hit];
      end
      touch_flow(hit);
    end else begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (!flow_valid[i] && !free_found) begin
          free_found = 1'b1;
          victim     = i;
        end
      end
      if (!free_found) begin
        evict_total++;
        for (int i = 1; i < ENTRIES; i++) begin
          if (flow_age[i] > flow_age[victim]) victim = i;
        end
      end
      flow_valid[victim] = 1'b1;
      flow_key[victim]   = key;
      flow_pkts[victim]  = 1;
      flow_bytes[victim] = ffwrl_pkg::BYTE_W'(len);
      flow_start[victim] = stamp;
      touch_flow(victim);
      v.new_entry = 1'b1;
      new_total++;
    end
    if (v.drop) drop_total++;
    packet_total++;
    return v;
  endfunction

  function automatic void add_row(logic [ffwrl_pkg::KEY_W-1:0] key,
                                  logic [ffwrl_pkg::LEN_W-1:0] len,
                                  logic [ffwrl_pkg::TIME_W-1:0] stamp, bit typed, logic drop,
                                  logic [ffwrl_pkg::PKT_W-1:0] count, logic new_entry);
    packet_row_t r;
    r.key            = key;
    r.len            = len;
    r.stamp          = stamp;
    r.typed          = typed;
    r.want.drop      = drop;
    r.want.count     = count;
    r.want.new_entry = new_entry;
    directed_rows.push_back(r);
  endfunction

  // Mostly known flows with a drifting clock, some fresh keys and time jumps
  function automatic packet_row_t random_row();
    packet_row_t r;
    r.typed = 1'b0;
    r.want  = '0;
    if ($urandom_range(0, 6) == 0) r.key = {$urandom, $urandom};
    else if ($urandom_range(0, 3) == 0) r.key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
    else r.key = key_pool[$urandom_range(0, 11)];
    case ($urandom_range(0, 9))
      0:       r.len = '0;
      1:       r.len = '1;
      2, 3:    r.len = ffwrl_pkg::LEN_W'($urandom);
      default: r.len = ffwrl_pkg::LEN_W'($urandom_range(40, 1500));
    endcase
    case ($urandom_range(0, 15))
      0:       now_base = {$urandom, $urandom};
      1:       now_base = now_base + 64'(win_len);
      2:       ;
      default: now_base = now_base + 64'($urandom_range(0, win_len / 8 + 1));
    endcase
    r.stamp = now_base;
    return r;
  endfunction

  task automatic write_reg(logic [ffwrl_pkg::CFG_IDX_W-1:0] idx,
                           logic [ffwrl_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = data;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      ffwrl_pkg::REG_MAX_PACKETS:   lim_packets = data[ffwrl_pkg::MAXP_W-1:0];
      ffwrl_pkg::REG_MAX_BYTES:     lim_bytes   = data[ffwrl_pkg::MAXB_W-1:0];
      ffwrl_pkg::REG_WINDOW_LENGTH: win_len     = data[ffwrl_pkg::WLEN_W-1:0];
      default:                      ;
    endcase
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // Hold the input and wait for every outstanding verdict
  task automatic drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
  endtask

  task automatic send_packet(packet_row_t r);
    int       gap;
    verdict_t v;
    if (send_idle_en && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 7);
      @(negedge clk);
      in_ch.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid         = 1'b1;
    in_ch.flow_key      = r.key;
    in_ch.packet_length = r.len;
    in_ch.now_time      = r.stamp;
    do @(posedge clk); while (!in_ch.ready);
    v = police_packet(r.key, r.len, r.stamp);
    pending_verdicts.push_back(r.typed ? r.want : v);
  endtask

  // Receiver: random stall bursts and one long hold-off on request
  initial begin
    int stall;
    stall         = 0;
    out_ch.ready  = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (stall > 0) stall--;
      else if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall         = LONG_HOLD;
      end else if (recv_idle_en && $urandom_range(0, 5) == 0) stall = $urandom_range(1, 7);
      out_ch.ready = (stall == 0);
    end
  end

  always @(posedge clk) begin
    verdict_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_verdicts.size() == 0) begin
        $error("verdict item with no packet outstanding");
        error_count++;
      end else begin
        want = pending_verdicts.pop_front();
        if (out_ch.drop !== want.drop) begin
          $error("drop: expected %0d, actual %0d", want.drop, out_ch.drop);
          error_count++;
        end
        if (out_ch.packet_count !== want.count) begin
          $error("packet_count: expected %0d, actual %0d", want.count, out_ch.packet_count);
          error_count++;
        end
        if (out_ch.new_entry !== want.new_entry) begin
          $error("new_entry: expected %0d, actual %0d", want.new_entry, out_ch.new_entry);
          error_count++;
        end
      end
    end
  end

  // Watchdog: end the run if no channel moves an item for too long
  initial begin
    int quiet;
    quiet = 0;
    @(posedge rst_n);
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    logic [ffwrl_pkg::MAXP_W-1:0] set_pkts;
    logic [ffwrl_pkg::MAXB_W-1:0] set_bytes;
    logic [ffwrl_pkg::WLEN_W-1:0] set_win;

    in_ch.valid         = 1'b0;
    in_ch.flow_key      = '0;
    in_ch.packet_length = '0;
    in_ch.now_time      = '0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = '0;
    cfg_ch.data         = '0;
    lim_packets         = '0;
    lim_bytes           = '0;
    win_len             = ffwrl_pkg::WINDOW_RESET;
    for (int i = 0; i < ENTRIES; i++) begin
      flow_valid[i] = 1'b0;
      flow_key[i]   = '0;
      flow_pkts[i]  = '0;
      flow_bytes[i] = '0;
      flow_start[i] = '0;
      flow_age[i]   = i;
    end
    error_count   = 0;
    packet_total  = 0;
    new_total     = 0;
    evict_total   = 0;
    restart_total = 0;
    drop_total    = 0;
    send_idle_en  = 1'b1;
    recv_idle_en  = 1'b1;
    long_hold_req = 1'b0;
    now_base      = '0;

    rst_n = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed table on reset registers: no limits, window length 1000000000
    add_row('0, '0, '0, 1, 0, 1, 1);
    add_row('0, '1, 64'd5, 1, 0, 2, 0);
    add_row('1, '1, '1, 1, 0, 1, 1);
    // Time wraps past zero: difference is one, still inside the window
    add_row('1, 16'd1, '0, 0, 0, 0, 0);
    // Exactly one window later: restart
    add_row('0, 16'd100, 64'd1_000_000_000, 1, 0, 1, 0);
    add_row('0, 16'd7, 64'd1_999_999_999, 0, 0, 0, 0);
    for (int k = 1; k <= 14; k++) begin
      add_row(64'(k), ffwrl_pkg::LEN_W'(k * 4681), 64'd2_000_000_000 + 64'(k), 1, 0, 1, 1);
    end
    // Table is full: evict the least recently used flows
    add_row(64'h5555_5555_5555_5555, 16'h5555, 64'd2_000_000_020, 0, 0, 0, 0);
    add_row('1, 16'hAAAA, 64'hAAAA_AAAA_AAAA_AAAA, 0, 0, 0, 0);
    add_row(64'd1, 16'd64, 64'd2_000_000_030, 0, 0, 0, 0);
    add_row('0, 16'd64, 64'd2_000_000_040, 0, 0, 0, 0);
    foreach (directed_rows[i]) send_packet(directed_rows[i]);

    for (int p = 0; p < PHASES; p++) begin
      drain();
      case (p)
        0: begin set_pkts = 4;  set_bytes = 0;    set_win = 100; end
        1: begin set_pkts = 0;  set_bytes = 3000; set_win = 50;  end
        // Zero window: every hit restarts
        2: begin set_pkts = 1;  set_bytes = 1;    set_win = 0;   end
        3: begin set_pkts = '1; set_bytes = '1;   set_win = '1;  end
        4: begin
          set_pkts  = ffwrl_pkg::MAXP_W'($urandom_range(2, 8));
          set_bytes = ffwrl_pkg::MAXB_W'($urandom_range(2000, 200000));
          set_win   = 1;
        end
        default: begin set_pkts = 3; set_bytes = 20000; set_win = 300; end
      endcase
      write_reg(ffwrl_pkg::REG_MAX_PACKETS, ffwrl_pkg::CFG_DATA_W'(set_pkts));
      write_reg(ffwrl_pkg::REG_MAX_BYTES, set_bytes);
      write_reg(ffwrl_pkg::REG_WINDOW_LENGTH, ffwrl_pkg::CFG_DATA_W'(set_win));
      write_reg(REG_SPARE, {8'($urandom_range(0, 255)), $urandom});
      for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = {$urandom, $urandom};
      now_base = {$urandom, $urandom};

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == PHASES - 1) begin
          send_idle_en = 1'b0;
          recv_idle_en = 1'b0;
        end else if (n % 48 == 0) begin
          send_idle_en = ($urandom_range(0, 2) != 0);
          recv_idle_en = ($urandom_range(0, 2) != 0);
        end
        // Back up the block with a long receiver hold-off
        if (p == 1 && n == 120) begin
          send_idle_en  = 1'b0;
          long_hold_req = 1'b1;
        end
        if (p == 2 && n == 150) drain();
        send_packet(random_row());
      end
    end

    drain();
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Policed %0d packets over %0d register settings plus reset values:", packet_total,
             PHASES);
    $display("  %0d new flows, %0d evictions, %0d window restarts, %0d drops", new_total,
             evict_total, restart_total, drop_total);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule : testbench
